/* sv/sjs_pkg.sv */
// Shared types and constants for the SRTF job scheduler.
// No dependencies; imported by every module of the block except sjs_ram.
`default_nettype none
package sjs_pkg;

   localparam int JOB_SLOTS = 16;
   localparam int SLOT_W    = $clog2(JOB_SLOTS);
   localparam int CNT_W     = SLOT_W + 1;

   typedef struct packed {
      logic        admit;
      logic [7:0]  job_id;
      logic [15:0] burst;
      logic        tick;
   } req_type;

   typedef struct packed {
      logic        ran;
      logic [7:0]  running_id;
      logic        completed;
      logic [31:0] wait_time;
      logic [31:0] turnaround_time;
      logic        rejected;
      logic [31:0] now_time;
   } rsp_type;

   // classified transaction handed from front to back
   typedef struct packed {
      req_type req;
      logic    adm_req;   // admission asked with a nonzero burst
   } item_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [31:0] arrival;
      logic [15:0] burst;
      logic [15:0] remaining;
      logic [31:0] order;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

/* sv/srtf_job_scheduler_core.sv */
// Top level of the shortest-remaining-time-first job scheduler.
// Depends on sjs_pkg, sjs_front, sjs_engine (and sjs_ram below it).
//
// Each request transaction may admit one job into a JOB_SLOTS-entry table
// and, with tick set, runs one time unit on the ready job with the least
// remaining time (ties to the earlier admission, then the lower slot).
// Every request yields exactly one response transaction. A request passes
// through a start state, a scan that reads one slot per cycle through the
// single read port of the slot RAM, a decide state that writes the admitted
// job, an update state that writes the running stored job back, and a
// state that loads the response register. That last state stalls while an
// earlier response still waits to be popped.
// A two-entry request queue keeps accepting while the back end works, and
// the response register lets the next request proceed while a response
// waits to be popped. No clearing pass is needed after reset: slot busy
// bits live in flip-flops and clear at once.
`default_nettype none
module srtf_job_scheduler_core
   import sjs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   // request queue side
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   // response queue side
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);
   logic     item_valid;
   logic     item_take;
   item_type item;

   // front: accepts and classifies request transactions
   sjs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   // back: scan, select, update, respond
   sjs_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );
endmodule
`default_nettype wire

/* sv/sjs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sjs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

/* sv/sjs_front.sv */
// Front end: two-entry request queue that classifies each transaction.
// Depends on sjs_pkg.
`default_nettype none
module sjs_front
   import sjs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_push,
   output logic          req_full,
   input  wire req_type  req_data,
   output logic          item_valid,
   input  wire logic     item_take,
   output item_type      item
);
   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;
   item_type   cls;

   assign req_full   = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_take && item_valid;

   always_comb begin
      cls.req     = req_data;
      cls.adm_req = req_data.admit && (req_data.burst != 16'd0);
      wr_ptr_in   = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in   = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in      = cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cls;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule
`default_nettype wire

/* sv/sjs_engine.sv */
// Back end: slot table scan, job selection, update and result register.
// Depends on sjs_pkg and sjs_ram.
`default_nettype none
module sjs_engine
   import sjs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     item_valid,
   output logic          item_take,
   input  wire item_type item,
   output logic          rsp_empty,
   input  wire logic     rsp_pop,
   output rsp_type       rsp_data
);
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0]     cmp_idx_ff, cmp_idx_in;
   item_type              cur_ff, cur_in;
   logic                  free_found_ff, free_found_in;
   logic [SLOT_W-1:0]     free_idx_ff, free_idx_in;
   logic                  best_found_ff, best_found_in;
   logic [SLOT_W-1:0]     best_idx_ff, best_idx_in;
   entry_type             best_ff, best_in;
   logic                  run_best_ff, run_best_in;
   logic [JOB_SLOTS-1:0]  busy_ff, busy_in;
   logic [31:0]           admit_count_ff, admit_count_in;
   logic [31:0]           time_ff, time_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  we;
   logic [SLOT_W-1:0]     waddr, raddr;
   entry_type             wdata, rd;
   logic [ENTRY_W-1:0]    rdata;

   logic                  admit_ok, adm_wins, run_adm;
   logic [31:0]           time_new, tat, run_arr;
   logic [15:0]           run_burst, rem_after;

   sjs_ram #(.WIDTH(ENTRY_W), .DEPTH(JOB_SLOTS)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rd        = rdata;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      cur_in         = cur_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_in        = best_ff;
      run_best_in    = run_best_ff;
      busy_in        = busy_ff;
      admit_count_in = admit_count_ff;
      time_in        = time_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_pop;
      item_take      = 1'b0;
      we             = 1'b0;
      waddr          = free_idx_ff;
      wdata          = best_ff;
      raddr          = cnt_ff[SLOT_W-1:0];

      admit_ok  = cur_ff.adm_req && free_found_ff;
      adm_wins  = !best_found_ff
                  || (cur_ff.req.burst < best_ff.remaining)
                  || ((cur_ff.req.burst == best_ff.remaining)
                      && ((admit_count_ff < best_ff.order)
                          || ((admit_count_ff == best_ff.order)
                              && (free_idx_ff < best_idx_ff))));
      run_adm   = cur_ff.req.tick && admit_ok && adm_wins;
      time_new  = (time_ff == 32'hFFFF_FFFF) ? time_ff : time_ff + 32'd1;
      run_arr   = run_adm ? time_ff : best_ff.arrival;
      run_burst = run_adm ? cur_ff.req.burst : best_ff.burst;
      rem_after = (run_adm ? cur_ff.req.burst : best_ff.remaining) - 16'd1;
      tat       = time_new - run_arr;

      // scan compare stage: data for slot cmp_idx_ff is on the read port
      if (cmp_vld_ff) begin
         if (!busy_ff[cmp_idx_ff]) begin
            if (!free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = cmp_idx_ff;
            end
         end else if (!best_found_ff || (rd.remaining < best_ff.remaining)
                      || ((rd.remaining == best_ff.remaining)
                          && (rd.order < best_ff.order))) begin
            best_found_in = 1'b1;
            best_idx_in   = cmp_idx_ff;
            best_in       = rd;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_take     = 1'b1;
               cur_in        = item;
               cnt_in        = '0;
               free_found_in = 1'b0;
               best_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(JOB_SLOTS)) begin
               state_in = ST_DECIDE;
            end else begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = cnt_ff[SLOT_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            res_in          = '0;
            res_in.rejected = cur_ff.req.admit && !admit_ok;
            res_in.now_time = time_ff;
            run_best_in     = 1'b0;
            if (admit_ok) begin
               we              = 1'b1;
               waddr           = free_idx_ff;
               wdata.id        = cur_ff.req.job_id;
               wdata.arrival   = time_ff;
               wdata.burst     = cur_ff.req.burst;
               wdata.remaining = run_adm ? rem_after : cur_ff.req.burst;
               wdata.order     = admit_count_ff;
               busy_in[free_idx_ff] = !(run_adm && (rem_after == 16'd0));
               if (admit_count_ff != 32'hFFFF_FFFF) begin
                  admit_count_in = admit_count_ff + 32'd1;
               end
            end
            if (cur_ff.req.tick) begin
               time_in         = time_new;
               res_in.now_time = time_new;
               if (run_adm || best_found_ff) begin
                  res_in.ran        = 1'b1;
                  res_in.running_id = run_adm ? cur_ff.req.job_id : best_ff.id;
                  run_best_in       = !run_adm;
                  if (rem_after == 16'd0) begin
                     res_in.completed       = 1'b1;
                     res_in.turnaround_time = tat;
                     res_in.wait_time = (tat >= {16'd0, run_burst})
                                        ? tat - {16'd0, run_burst} : 32'd0;
                     if (!run_adm) begin
                        busy_in[best_idx_ff] = 1'b0;
                     end
                  end
               end
            end
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (run_best_ff) begin
               we              = 1'b1;
               waddr           = best_idx_ff;
               wdata           = best_ff;
               wdata.remaining = best_ff.remaining - 16'd1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      cmp_idx_ff    <= cmp_idx_in;
      cur_ff        <= cur_in;
      free_idx_ff   <= free_idx_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
      free_found_ff <= free_found_in;
      best_found_ff <= best_found_in;
      run_best_ff   <= run_best_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         cmp_vld_ff     <= 1'b0;
         busy_ff        <= '0;
         admit_count_ff <= '0;
         time_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cmp_vld_ff     <= cmp_vld_in;
         busy_ff        <= busy_in;
         admit_count_ff <= admit_count_in;
         time_ff        <= time_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire
